[rtl/fsf_pkg.sv]
// Package for the format string formatter: types, character codes and lookup functions.
package fsf_pkg;

   // Character codes used by the parser.
   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_PCT   = 8'h25;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_D     = 8'h64;
   localparam logic [7:0] CHR_X     = 8'h78;
   localparam logic [7:0] CHR_P     = 8'h70;
   localparam logic [7:0] CHR_S     = 8'h73;
   localparam logic [7:0] CHR_C     = 8'h63;

   // Digit buffer: a 32-bit word has at most ten decimal digits.
   localparam int MAX_DIGITS = 10;
   localparam int CNT_W      = 4;
   localparam int NULL_LEN   = 6;
   localparam int NULL_W     = 3;

   // Reciprocal of ten scaled by two to the 35th, rounded up.
   localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_PCT   = 2'd1,
      MODE_STR   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAR,
      ST_PCT,
      ST_NULL,
      ST_QUOT,
      ST_DIGIT,
      ST_SIGN,
      ST_NUM
   } state_type;

   // Commands from the sequencer to the shared divide unit.
   typedef struct packed {
      logic load;
      logic hex;
      logic quot;
      logic commit;
   } div_ctrl_type;

   // Status from the shared divide unit.
   typedef struct packed {
      logic [3:0] digit;
      logic       done;
   } div_stat_type;

   // Upper-case hex digit for a four-bit value.
   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else begin
         c = 8'h37 + {4'd0, d};
      end
      return c;
   endfunction

   // Characters of the text printed for a null string.
   function automatic logic [7:0] null_char(input logic [NULL_W-1:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0:    c = 8'h28;
         3'd1:    c = 8'h6E;
         3'd2:    c = 8'h75;
         3'd3:    c = 8'h6C;
         3'd4:    c = 8'h6C;
         default: c = 8'h29;
      endcase
      return c;
   endfunction

endpackage

[rtl/fsf_if.sv]
// Handshake interfaces for the request and result channels.
interface fsf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  char_in;
   logic [31:0] arg;

   modport source (output valid, output char_in, output arg, input ready);
   modport sink (input valid, input char_in, input arg, output ready);
endinterface

interface fsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink (input valid, input out_char, input last, output ready);
endinterface

[rtl/fsf_div_unit.sv]
// Shared divide unit: takes one digit off a word per quotient and commit step, base ten or sixteen.
module fsf_div_unit
   import fsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   input  logic [31:0]  load_value,
   output div_stat_type stat
);

   logic [31:0] x_ff, x_in;
   logic [31:0] q_ff, q_in;
   logic        hex_ff, hex_in;
   logic [63:0] prod;
   logic [3:0]  q10_low;

   // Quotient by ten through the scaled reciprocal; by sixteen it is a shift.
   assign prod = {32'd0, x_ff} * {32'd0, DIV10_RECIP};

   always_comb begin
      x_in   = x_ff;
      q_in   = q_ff;
      hex_in = hex_ff;
      if (ctrl.load) begin
         x_in   = load_value;
         hex_in = ctrl.hex;
      end else if (ctrl.quot) begin
         q_in = hex_ff ? {4'd0, x_ff[31:4]} : {3'd0, prod[63:35]};
      end else if (ctrl.commit) begin
         x_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_ff <= 1'b0;
      end else begin
         hex_ff <= hex_in;
      end
      x_ff <= x_in;
      q_ff <= q_in;
   end

   // The remainder needs only the low four bits of the quotient times the base.
   assign q10_low    = {q_ff[0], 3'd0} + {q_ff[2:0], 1'b0};
   assign stat.digit = hex_ff ? x_ff[3:0] : (x_ff[3:0] - q10_low);
   assign stat.done  = (q_ff == 32'd0);

endmodule

[rtl/format_string_formatter_core.sv]
// A plain byte gives its character through the ST_CHAR state and then the result register.
// A number is taken apart in the shared divide unit, one digit per quotient and commit step,
// then given out one character at a time (a sign for a negative %d, and up to ten digits).
// One request at a time: a request that gives out nothing leaves the block idle, and a
// result that waits for rsp_ch.ready holds back the next character and the next request.
// Reset returns the parser to plain text and empties the result register.
module format_string_formatter_core
   import fsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   fsf_req_if.sink          req_ch,
   fsf_rsp_if.source        rsp_ch
);

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [7:0]          ch_ff, ch_in;
   logic [NULL_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [3:0]          digits_ff [MAX_DIGITS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   div_ctrl_type        div_ctrl;
   div_stat_type        div_stat;
   logic [31:0]         load_value;
   logic                accept;
   logic                out_free;
   logic                emit;
   logic [7:0]          emit_char;
   logic                emit_last;
   logic                push_digit;
   logic [CNT_W-1:0]    rd_idx;

   fsf_div_unit u_div (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .load_value (load_value),
      .stat       (div_stat)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rd_idx       = cnt_ff - 4'd1;

   // Sequencer: parses the request, drives the divide unit and picks the next character.
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      ch_in      = ch_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      div_ctrl   = '0;
      load_value = req_ch.arg;
      emit       = 1'b0;
      emit_char  = ch_ff;
      emit_last  = 1'b1;
      push_digit = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_ff)
                  MODE_PCT: begin
                     mode_in = MODE_PLAIN;
                     priority if (req_ch.char_in == CHR_NUL) begin
                        mode_in = MODE_PLAIN;
                     end else if (req_ch.char_in == CHR_D) begin
                        neg_in       = req_ch.arg[31];
                        load_value   = req_ch.arg[31] ? (32'd0 - req_ch.arg) : req_ch.arg;
                        div_ctrl.load = 1'b1;
                        cnt_in       = '0;
                        state_in     = ST_QUOT;
                     end else if (req_ch.char_in == CHR_X || req_ch.char_in == CHR_P) begin
                        neg_in        = 1'b0;
                        div_ctrl.load = 1'b1;
                        div_ctrl.hex  = 1'b1;
                        cnt_in        = '0;
                        state_in      = ST_QUOT;
                     end else if (req_ch.char_in == CHR_S) begin
                        if (req_ch.arg == 32'd0) begin
                           idx_in   = '0;
                           state_in = ST_NULL;
                        end else begin
                           mode_in = MODE_STR;
                        end
                     end else if (req_ch.char_in == CHR_C) begin
                        ch_in    = req_ch.arg[7:0];
                        state_in = ST_CHAR;
                     end else if (req_ch.char_in == CHR_PCT) begin
                        ch_in    = CHR_PCT;
                        state_in = ST_CHAR;
                     end else begin
                        ch_in    = req_ch.char_in;
                        state_in = ST_PCT;
                     end
                  end
                  MODE_STR: begin
                     if (req_ch.char_in == CHR_NUL) begin
                        mode_in = MODE_PLAIN;
                     end else begin
                        ch_in    = req_ch.char_in;
                        state_in = ST_CHAR;
                     end
                  end
                  default: begin
                     mode_in = MODE_PLAIN;
                     priority if (req_ch.char_in == CHR_NUL) begin
                        mode_in = MODE_PLAIN;
                     end else if (req_ch.char_in == CHR_PCT) begin
                        mode_in = MODE_PCT;
                     end else begin
                        ch_in    = req_ch.char_in;
                        state_in = ST_CHAR;
                     end
                  end
               endcase
            end
         end
         ST_CHAR: begin
            emit = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_PCT: begin
            emit      = 1'b1;
            emit_char = CHR_PCT;
            emit_last = 1'b0;
            if (out_free) begin
               state_in = ST_CHAR;
            end
         end
         ST_NULL: begin
            emit      = 1'b1;
            emit_char = null_char(idx_ff);
            emit_last = (idx_ff == NULL_W'(NULL_LEN - 1));
            if (out_free) begin
               idx_in = idx_ff + 3'd1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_QUOT: begin
            div_ctrl.quot = 1'b1;
            state_in      = ST_DIGIT;
         end
         ST_DIGIT: begin
            div_ctrl.commit = 1'b1;
            push_digit      = 1'b1;
            cnt_in          = cnt_ff + 4'd1;
            if (div_stat.done) begin
               state_in = neg_ff ? ST_SIGN : ST_NUM;
            end else begin
               state_in = ST_QUOT;
            end
         end
         ST_SIGN: begin
            emit      = 1'b1;
            emit_char = CHR_MINUS;
            emit_last = 1'b0;
            if (out_free) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            emit      = 1'b1;
            emit_char = hex_char(digits_ff[rd_idx]);
            emit_last = (cnt_ff == 4'd1);
            if (out_free) begin
               cnt_in = rd_idx;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: loaded with the next character whenever it is empty or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_PLAIN;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         neg_ff       <= neg_in;
      end
   end

   // Payload registers and the digit buffer.
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (push_digit) begin
         digits_ff[cnt_ff] <= div_stat.digit;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_char = rsp_char_ff;
   assign rsp_ch.last     = rsp_last_ff;

   // The digit buffer never overflows.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond buffer depth");

   // Digits are only read out while some remain.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NUM |-> cnt_ff != '0)
      else $error("number output with empty digit buffer");

   // A quotient step is always followed by its commit step.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUOT |=> state_ff == ST_DIGIT)
      else $error("quotient step not committed");

   // Reset empties the result register.
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

endmodule

[tb/sv/fsf_output_checker.sv]
`timescale 1ns / 1ps
// Output checker for the format string formatter: predicts each character and compares it.
module fsf_output_checker
   import fsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic [31:0] req_arg,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_char,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count,
   output int          chars_checked
);

   localparam int          REPORT_LIMIT = 10;
   localparam logic [47:0] NULL_TEXT    = "(null)";
   localparam logic [7:0]  CHR_ZERO     = "0";
   localparam logic [7:0]  CHR_UPPER_A  = "A";

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } out_char_type;

   mode_type     format_mode;
   logic [7:0]   request_chars[$];
   out_char_type pending_chars[$];

   // Append the digits of a word, most significant first, with a sign for negative decimals.
   task automatic append_number(input logic [31:0] word, input bit decimal);
      logic [7:0]  digit_chars[$];
      logic [31:0] magnitude;
      logic [31:0] radix;
      logic [3:0]  digit;
      magnitude = word;
      radix = decimal ? 32'd10 : 32'd16;
      if (decimal && word[31]) begin
         magnitude = 32'd0 - word;
      end
      do begin
         digit = 4'(magnitude % radix);
         if (digit < 4'd10) begin
            digit_chars.push_front(CHR_ZERO + {4'd0, digit});
         end else begin
            digit_chars.push_front(CHR_UPPER_A + {4'd0, digit} - 8'd10);
         end
         magnitude = magnitude / radix;
      end while (magnitude != 32'd0);
      if (decimal && word[31]) begin
         request_chars.push_back(CHR_MINUS);
      end
      foreach (digit_chars[i]) begin
         request_chars.push_back(digit_chars[i]);
      end
   endtask

   // Work out the characters that one request causes and queue them behind earlier ones.
   task automatic format_request(input logic [7:0] c, input logic [31:0] a);
      request_chars.delete();
      case (format_mode)
         MODE_PCT: begin
            format_mode = MODE_PLAIN;
            if (c == CHR_NUL) begin
               // End of the format string right after a percent sign.
            end else if (c == CHR_D) begin
               append_number(a, 1'b1);
            end else if (c == CHR_X || c == CHR_P) begin
               append_number(a, 1'b0);
            end else if (c == CHR_S) begin
               if (a == 32'd0) begin
                  for (int i = 0; i < NULL_LEN; i++) begin
                     request_chars.push_back(NULL_TEXT[47 - 8 * i -: 8]);
                  end
               end else begin
                  format_mode = MODE_STR;
               end
            end else if (c == CHR_C) begin
               request_chars.push_back(a[7:0]);
            end else if (c == CHR_PCT) begin
               request_chars.push_back(CHR_PCT);
            end else begin
               request_chars.push_back(CHR_PCT);
               request_chars.push_back(c);
            end
         end
         MODE_STR: begin
            if (c == CHR_NUL) begin
               format_mode = MODE_PLAIN;
            end else begin
               request_chars.push_back(c);
            end
         end
         default: begin
            format_mode = MODE_PLAIN;
            if (c == CHR_PCT) begin
               format_mode = MODE_PCT;
            end else if (c != CHR_NUL) begin
               request_chars.push_back(c);
            end
         end
      endcase
      foreach (request_chars[i]) begin
         pending_chars.push_back('{out_char: request_chars[i],
                                   last: (i == request_chars.size() - 1)});
      end
   endtask

   // Predict on each accepted request and compare each accepted result with the oldest one.
   always @(posedge clock) begin
      out_char_type expected;
      if (reset) begin
         format_mode = MODE_PLAIN;
         pending_chars.delete();
         fail_count = 0;
         chars_checked = 0;
      end else begin
         if (req_valid && req_ready) begin
            format_request(req_char_in, req_arg);
         end
         if (rsp_valid && rsp_ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected character 0x%02h last=%0b with none pending",
                           $time, rsp_out_char, rsp_last);
               end
               fail_count++;
            end else begin
               expected = pending_chars.pop_front();
               if (expected.out_char !== rsp_out_char || expected.last !== rsp_last) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected 0x%02h/%0b, got 0x%02h/%0b",
                              $time, expected.out_char, expected.last,
                              rsp_out_char, rsp_last);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_count = pending_chars.size();
   end

endmodule

[tb/sv/format_string_formatter_core_tb.sv]
`timescale 1ns / 1ps
// Top of the format string formatter testbench: clock, reset, request stimulus and verdict.
module format_string_formatter_core_tb
   import fsf_pkg::*;
();

   localparam int         RANDOM_ITEMS   = 155;
   localparam int         IDLE_LIMIT     = 4000;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         RESET_CYCLES   = 6;
   localparam logic [7:0] CHR_OTHER_SEL  = "q";
   localparam logic [7:0] CHR_SUBSTITUTE = "!";

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;

   int fail_count;
   int pending_count;
   int chars_checked;
   int sent_count = 0;
   int directed_count = 0;
   int conversion_count = 0;
   int string_count = 0;
   int noise_count = 0;
   int idle_cycles = 0;

   fsf_req_if req_ch ();
   fsf_rsp_if rsp_ch ();

   format_string_formatter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   fsf_output_checker output_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_char_in   (req_ch.char_in),
      .req_arg       (req_ch.arg),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_out_char  (rsp_ch.out_char),
      .rsp_last      (rsp_ch.last),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .chars_checked (chars_checked)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long; none at all in quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Argument words weighted towards the extremes and short numbers.
   function automatic logic [31:0] random_arg();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h7FFF_FFFF;
         4, 5:    return 32'($urandom_range(0, 999));
         default: return $urandom;
      endcase
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [7:0] c, input logic [31:0] a);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid   <= 1'b0;
         req_ch.char_in <= 8'($urandom);
         req_ch.arg     <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= c;
      req_ch.arg     <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // A percent sign followed by its selector byte.
   task automatic send_conversion(input logic [7:0] sel, input logic [31:0] a);
      send_request(CHR_PCT, $urandom);
      send_request(sel, a);
   endtask

   // Result side: ready drops for random stretches, except in quiet stretches.
   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold = pick_gap();
         end else begin
            rsp_ch.ready <= 1'b1;
            hold = $urandom_range(0, 3);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: reset, directed cases, random format strings, then drain and verdict.
   initial begin
      logic [7:0] sel;
      logic [7:0] byte_value;
      int         str_len;
      req_ch.valid   = 1'b0;
      req_ch.char_in = 8'd0;
      req_ch.arg     = 32'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme bytes, every conversion and the special cases.
      send_request(8'h48, 32'h0000_0000);
      send_request(8'hFF, 32'hFFFF_FFFF);
      send_conversion(CHR_D, 32'h8000_0000);
      send_conversion(CHR_D, 32'hFFFF_FFFF);
      send_conversion(CHR_X, 32'hFFFF_FFFF);
      send_conversion(CHR_P, 32'h0000_0000);
      send_conversion(CHR_C, 32'hABCD_EF00);
      send_conversion(CHR_PCT, 32'h1234_5678);
      send_conversion(CHR_OTHER_SEL, 32'h0000_0001);
      send_conversion(CHR_S, 32'h0000_0000);
      send_conversion(CHR_S, 32'h0000_1000);
      send_request(CHR_PCT, 32'h0);
      send_request(8'hFF, 32'h0);
      send_request(CHR_NUL, 32'hFFFF_FFFF);
      send_conversion(CHR_NUL, 32'h0);
      send_request(CHR_NUL, 32'h0);
      directed_count = sent_count;

      // Random: mostly well-formed pieces of format strings, some noise.
      while (sent_count < directed_count + RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            quiet = !quiet;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               byte_value = 8'($urandom_range(1, 255));
               if (byte_value == CHR_PCT) begin
                  byte_value = CHR_SUBSTITUTE;
               end
               send_request(byte_value, random_arg());
            end
            7, 8, 9, 10, 11, 12, 13, 14: begin
               case ($urandom_range(0, 8))
                  0:       sel = CHR_D;
                  1:       sel = CHR_X;
                  2:       sel = CHR_P;
                  3:       sel = CHR_C;
                  4:       sel = CHR_PCT;
                  5, 6:    sel = CHR_S;
                  7:       sel = 8'($urandom);
                  default: sel = CHR_NUL;
               endcase
               conversion_count++;
               if (sel == CHR_S && $urandom_range(0, 4) != 0) begin
                  // A string argument: its bytes follow up to a zero byte.
                  string_count++;
                  send_conversion(CHR_S, 32'($urandom_range(1, 32'hFFFF_FFFF)));
                  str_len = $urandom_range(0, 6);
                  repeat (str_len) begin
                     if ($urandom_range(0, 5) == 0) begin
                        send_request(CHR_PCT, random_arg());
                     end else begin
                        send_request(8'($urandom_range(1, 255)), random_arg());
                     end
                  end
                  send_request(CHR_NUL, random_arg());
               end else begin
                  send_conversion(sel, random_arg());
               end
            end
            15, 16: begin
               send_request(CHR_NUL, random_arg());
            end
            default: begin
               noise_count++;
               send_request(8'($urandom), $urandom);
            end
         endcase
      end
      quiet = 1'b0;
      @(negedge clock);
      req_ch.valid <= 1'b0;

      // Drain: wait for every pending character, then a little longer for strays.
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d directed), checked %0d output characters.",
               sent_count, directed_count, chars_checked);
      $display("Random part: %0d conversions, %0d string arguments, %0d noise bytes.",
               conversion_count, string_count, noise_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures, %0d characters still pending", fail_count, pending_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
